[design/c3if_pkg.sv]
// Shared types and constants for the 3x3 image filter.
// No dependencies; used by every module of the block.
`default_nettype none

package c3if_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int COEFF_BITS_DEF = 16;

  localparam int KSIZE       = 3;
  localparam int MIN_DIM     = 3;
  localparam int LANE_BITS   = 16;
  localparam int KROW_W      = 48;
  localparam int DIM_REG_W   = 11;
  localparam int DIM_RESET   = 1024;
  localparam int PIX_IN_W    = 8;
  localparam int PIX_WIDE_W  = 16;
  localparam int OUT_W       = 28;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  localparam longint OUT_MAX = 134217727;
  localparam longint OUT_MIN = -134217728;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_TOP   = 3'd0,
    REG_KERNEL_MID   = 3'd1,
    REG_KERNEL_BOT   = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  // Per-pixel control that rides along the pipeline.
  typedef struct packed {
    logic emit;   // window lies inside the image
    logic eof;    // pixel ends the frame
  } c3if_tag_t;

endpackage

`default_nettype wire

[design/c3if_line_mem.sv]
// Line store stage: one synchronous RAM holding the two previous lines per column.
// Read at transfer, modify and write back as the pixel moves on. Uses c3if_pkg.
`default_nettype none

module c3if_line_mem #(
  parameter int MAX_WIDTH  = c3if_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  in_col,
  input  wire logic [PIXEL_BITS-1:0]         in_pixel,
  input  wire c3if_pkg::c3if_tag_t           in_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [PIXEL_BITS-1:0]              out_top,
  output logic [PIXEL_BITS-1:0]              out_mid,
  output logic [PIXEL_BITS-1:0]              out_pix,
  output c3if_pkg::c3if_tag_t                out_tag
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FILL_W = $clog2(MAX_WIDTH + 1);

  // Entry layout: {line y-2, line y-1}.
  logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q;

  logic                  v1;
  logic [COL_W-1:0]      col1;
  logic [PIXEL_BITS-1:0] pix1;
  logic                  written1;
  c3if_pkg::c3if_tag_t   tag1;

  // Columns are visited from 0 upward, so the written entries are always
  // the range [0, fill). Anything at or past fill is read back as zero.
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] col_ext;
  logic              in_xfer;
  logic              out_xfer;

  assign col_ext  = FILL_W'(in_col);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = v1 && out_ready;
  assign in_ready = !v1 || out_ready;

  assign out_valid = v1;
  assign out_top   = written1 ? rd_q[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
  assign out_mid   = written1 ? rd_q[PIXEL_BITS-1:0] : '0;
  assign out_pix   = pix1;
  assign out_tag   = tag1;

  // A column comes back at least three pixels later, after the write-back
  // below, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_q <= mem[in_col];
    end
    if (out_xfer) begin
      mem[col1] <= {out_mid, pix1};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col1     <= in_col;
      pix1     <= in_pixel;
      tag1     <= in_tag;
      written1 <= col_ext < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      fill <= '0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (in_xfer && (col_ext == fill)) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/c3if_mac.sv]
// 3x3 window, nine multipliers, two-level adder tree, saturation, output register.
// Elastic stages with per-stage valid. Uses c3if_pkg.
`default_nettype none

module c3if_mac #(
  parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEF,
  parameter int COEFF_BITS = c3if_pkg::COEFF_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [PIXEL_BITS-1:0]              in_top,
  input  wire logic [PIXEL_BITS-1:0]              in_mid,
  input  wire logic [PIXEL_BITS-1:0]              in_pix,
  input  wire c3if_pkg::c3if_tag_t                in_tag,
  input  wire logic [c3if_pkg::KROW_W-1:0]        k_top,
  input  wire logic [c3if_pkg::KROW_W-1:0]        k_mid,
  input  wire logic [c3if_pkg::KROW_W-1:0]        k_bot,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [c3if_pkg::OUT_W-1:0]       out_filtered,
  output logic                                    out_last
);

  localparam int K      = c3if_pkg::KSIZE;
  localparam int PROD_W = PIXEL_BITS + 1 + COEFF_BITS;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;
  localparam int ACC_W  = (SUM_W > c3if_pkg::OUT_W) ? SUM_W : c3if_pkg::OUT_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(c3if_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(c3if_pkg::OUT_MIN);

  logic [PIXEL_BITS-1:0]          win [K][K];
  logic signed [COEFF_BITS-1:0]   coef [K][K];
  logic signed [PROD_W-1:0]       prod_c [K][K];
  logic signed [PROD_W-1:0]       prod [K][K];
  logic signed [ROW_W-1:0]        row_c [K];
  logic signed [ROW_W-1:0]        row_sum [K];
  logic signed [SUM_W-1:0]        sum_c;
  logic signed [ACC_W-1:0]        acc_c;
  logic signed [ACC_W-1:0]        sat_c;
  logic [c3if_pkg::KROW_W-1:0]    krow [K];

  logic v2, v3, v4, vo;
  logic eof2, eof3, eof4;
  logic rdy3, rdy4, rdy_o;

  assign rdy_o    = !vo || out_ready;
  assign rdy4     = !v4 || rdy_o;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = !v2 || rdy3;

  assign krow[0] = k_top;
  assign krow[1] = k_mid;
  assign krow[2] = k_bot;

  always_comb begin
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K; c++) begin
        coef[r][c]   = $signed(krow[r][c*c3if_pkg::LANE_BITS +: COEFF_BITS]);
        prod_c[r][c] = PROD_W'($signed({1'b0, win[r][c]})) * PROD_W'(coef[r][c]);
      end
      row_c[r] = ROW_W'(prod[r][0]) + ROW_W'(prod[r][1]) + ROW_W'(prod[r][2]);
    end
    sum_c = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
    acc_c = ACC_W'(sum_c);
    if (acc_c > SAT_HI) begin
      sat_c = SAT_HI;
    end else if (acc_c < SAT_LO) begin
      sat_c = SAT_LO;
    end else begin
      sat_c = acc_c;
    end
  end

  // Window shifts on every pixel, also those that give no result, so it
  // only moves when the stage holding it is free.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < K; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= in_top;
      win[1][2] <= in_mid;
      win[2][2] <= in_pix;
      eof2      <= in_tag.eof;
    end
    if (rdy3) begin
      prod <= prod_c;
      eof3 <= eof2;
    end
    if (rdy4) begin
      row_sum <= row_c;
      eof4    <= eof3;
    end
    if (rdy_o) begin
      out_filtered <= sat_c[c3if_pkg::OUT_W-1:0];
      out_last     <= eof4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid && in_tag.emit;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy_o) begin
        vo <= v4;
      end
    end
  end

  assign out_valid = vo;

endmodule

`default_nettype wire

[design/conv3x3_image_filter_top.sv]
// 3x3 valid-region image filter: one pixel per cycle while m_tready does not stall the output.
// 1 pixel/clock if not stalled, set by the line RAM read-modify-write and 9 parallel multipliers.
// Stages: line RAM read, window, products, row sums, saturated output register.
// Synchronous reset clears counters, valids and kernel registers; width and height reset to 1024.
// Line RAM is not swept: a fill count makes never-written columns read as zero.
// Holds config registers and raster counters; uses c3if_pkg, c3if_line_mem, c3if_mac.
`default_nettype none

module conv3x3_image_filter_top #(
  parameter int MAX_WIDTH  = c3if_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3if_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEF,
  parameter int COEFF_BITS = c3if_pkg::COEFF_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [c3if_pkg::PIX_IN_W-1:0]       s_tdata,    // [7:0] pixel
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [c3if_pkg::OUT_TDATA_W-1:0]         m_tdata,    // [27:0] filtered, rest zero
  output logic                                     m_tlast,    // frame_last
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [c3if_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [c3if_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LN_W  = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP  = (WW > c3if_pkg::DIM_REG_W) ? WW : c3if_pkg::DIM_REG_W;
  localparam int HCMP  = (HW > c3if_pkg::DIM_REG_W) ? HW : c3if_pkg::DIM_REG_W;

  logic [c3if_pkg::KROW_W-1:0]    k_top, k_mid, k_bot;
  logic [c3if_pkg::DIM_REG_W-1:0] img_w, img_h;

  logic [COL_W-1:0] col;
  logic [LN_W-1:0]  line;

  logic [WCMP-1:0] w_ext;
  logic [HCMP-1:0] h_ext;
  logic [WW-1:0]   w_eff, col_inc;
  logic [HW-1:0]   h_eff, line_inc;
  logic            eol, eof, emit;
  logic            in_xfer;

  logic [c3if_pkg::PIX_WIDE_W-1:0] pix_wide;
  logic [PIXEL_BITS-1:0]           pix;
  c3if_pkg::c3if_tag_t             tag;

  logic                  lm_valid, lm_ready;
  logic [PIXEL_BITS-1:0] lm_top, lm_mid, lm_pix;
  c3if_pkg::c3if_tag_t   lm_tag;

  logic signed [c3if_pkg::OUT_W-1:0] filtered;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_top <= '0;
      k_mid <= '0;
      k_bot <= '0;
      img_w <= c3if_pkg::DIM_REG_W'(c3if_pkg::DIM_RESET);
      img_h <= c3if_pkg::DIM_REG_W'(c3if_pkg::DIM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (c3if_pkg::cfg_reg_t'(cfg_index))
        c3if_pkg::REG_KERNEL_TOP:   k_top <= cfg_data;
        c3if_pkg::REG_KERNEL_MID:   k_mid <= cfg_data;
        c3if_pkg::REG_KERNEL_BOT:   k_bot <= cfg_data;
        c3if_pkg::REG_IMAGE_WIDTH:  img_w <= cfg_data[c3if_pkg::DIM_REG_W-1:0];
        c3if_pkg::REG_IMAGE_HEIGHT: img_h <= cfg_data[c3if_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size
  assign w_ext = WCMP'(img_w);
  assign h_ext = HCMP'(img_h);

  always_comb begin
    if (w_ext < WCMP'(c3if_pkg::MIN_DIM)) begin
      w_eff = WW'(c3if_pkg::MIN_DIM);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (h_ext < HCMP'(c3if_pkg::MIN_DIM)) begin
      h_eff = HW'(c3if_pkg::MIN_DIM);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  // Raster position
  assign col_inc  = WW'(col) + WW'(1);
  assign line_inc = HW'(line) + HW'(1);
  assign eol      = col_inc >= w_eff;
  assign eof      = eol && (line_inc >= h_eff);
  assign emit     = (col >= COL_W'(2)) && (line >= LN_W'(2));
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      line <= '0;
    end else if (in_xfer) begin
      if (eol) begin
        col  <= '0;
        line <= eof ? '0 : line_inc[LN_W-1:0];
      end else begin
        col  <= col_inc[COL_W-1:0];
      end
    end
  end

  assign pix_wide = c3if_pkg::PIX_WIDE_W'(s_tdata);
  assign pix      = pix_wide[PIXEL_BITS-1:0];
  assign tag.emit = emit;
  assign tag.eof  = eof;

  c3if_line_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_col    (col),
    .in_pixel  (pix),
    .in_tag    (tag),
    .out_valid (lm_valid),
    .out_ready (lm_ready),
    .out_top   (lm_top),
    .out_mid   (lm_mid),
    .out_pix   (lm_pix),
    .out_tag   (lm_tag)
  );

  c3if_mac #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (lm_valid),
    .in_ready     (lm_ready),
    .in_top       (lm_top),
    .in_mid       (lm_mid),
    .in_pix       (lm_pix),
    .in_tag       (lm_tag),
    .k_top        (k_top),
    .k_mid        (k_mid),
    .k_bot        (k_bot),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_filtered (filtered),
    .out_last     (m_tlast)
  );

  assign m_tdata = {{(c3if_pkg::OUT_TDATA_W - c3if_pkg::OUT_W){1'b0}}, filtered};

endmodule

`default_nettype wire
